// File: rtl/iabst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_pkg
// Shared types and constants for the implicit-array BST key map.
// ----------------------------------------------------------------------------
package iabst_pkg;

  localparam int LEVELS_DEF    = 10;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int IN_KEY_W      = 32;
  localparam int SLOT_W        = 10;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic                command;
    logic [IN_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic term;
    logic out_free;
  } ctrl_sts_t;

endpackage : iabst_pkg
`default_nettype wire

// File: rtl/iabst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_ctrl
// Sequencer: clearing pass after reset, then accept / descend / finish.
// ----------------------------------------------------------------------------
module iabst_ctrl import iabst_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (sts.clr_last) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.term && sts.out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (st_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_WALK: begin
        cmd.step   = !sts.term;
        cmd.finish = sts.term && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : iabst_ctrl
`default_nettype wire

// File: rtl/iabst_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_dp
// Node memory {valid, key}, descent index, key compare and result register.
// ----------------------------------------------------------------------------
module iabst_dp import iabst_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts
);

  localparam int unsigned CAP  = (1 << LEVELS) - 1;
  localparam int          IDXW = LEVELS + 1;
  localparam int          MEMW = KEY_WIDTH + 1;

  logic [MEMW-1:0]      mem [0:CAP-1];
  logic [MEMW-1:0]      rd_data_r;
  logic [LEVELS-1:0]    clr_r, clr_nxt;
  logic [IDXW-1:0]      idx_r, idx_nxt;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 cmd_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r;

  logic                 over, nvld, eq, lt, nxt_over;
  logic [KEY_WIDTH-1:0] nkey;
  logic [IDXW-1:0]      nxt_idx;
  logic                 rd_en, wr_en;
  logic [LEVELS-1:0]    rd_addr, wr_addr;
  logic [MEMW-1:0]      wr_data;

  assign nkey     = rd_data_r[KEY_WIDTH-1:0];
  assign nvld     = rd_data_r[KEY_WIDTH];
  assign over     = idx_r >= IDXW'(CAP);
  assign eq       = nkey == key_r;
  assign lt       = key_r < nkey;
  assign nxt_idx  = {idx_r[LEVELS-1:0], 1'b0} + (lt ? IDXW'(1) : IDXW'(2));
  assign nxt_over = nxt_idx >= IDXW'(CAP);

  assign sts.term     = over || !nvld || eq;
  assign sts.clr_last = clr_r == LEVELS'(CAP - 1);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.step) begin
      rd_en   = !nxt_over;
      rd_addr = nxt_idx[LEVELS-1:0];
    end else if (cmd.start) begin
      rd_en   = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[LEVELS-1:0];
    wr_data = {1'b1, key_r};
    if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (cmd.finish) begin
      wr_en = (cmd_r == CMD_INSERT) && !over && !nvld;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = nxt_idx;
    end
  end

  assign clr_nxt       = cmd.clear_wr ? clr_r + LEVELS'(1) : clr_r;
  assign out_valid_nxt = cmd.finish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.start) begin
      key_r <= KEY_WIDTH'(in_data.key);
      cmd_r <= in_data.command;
    end
    if (cmd.finish) begin
      out_r.hit      <= !over && nvld && eq;
      out_r.overflow <= over;
      out_r.slot     <= over ? '0 : SLOT_W'(idx_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : iabst_dp
`default_nettype wire

// File: rtl/implicit_array_bst_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_array_bst_map_unit
// Key map held as a binary search tree in a flat array (children 2i+1, 2i+2).
// ----------------------------------------------------------------------------
// Each item is a lookup or an insert of a key. The block walks from the root,
// one level per cycle through a single-port node memory with registered read,
// and returns hit, slot and overflow; an insert that reaches an empty slot
// claims it. An item occupies the block until its walk ends, with one memory
// read and key compare per level. The result waits in an output register, so
// the next item is taken while it is still pending. After reset a clearing
// pass empties the node memory; in_stall stays high until it completes.
// ----------------------------------------------------------------------------
module implicit_array_bst_map_unit import iabst_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  iabst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iabst_dp #(
    .LEVELS    (LEVELS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule : implicit_array_bst_map_unit
`default_nettype wire
